// File: rtl/core/svm_pkg.sv
// Shared opcodes and types for the stack machine execute unit.
`timescale 1ns / 1ps
`default_nettype none
package svm_pkg;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned CMD_W   = 5;
  localparam int unsigned SLOT_W  = 8;
  localparam int unsigned LABEL_W = 8;

  typedef enum logic [CMD_W-1:0] {
    PUSH     = 5'd0,
    OP_LOAD  = 5'd1,
    OP_STORE = 5'd2,
    OP_READ  = 5'd3,
    OP_PRINT = 5'd4,
    OP_ADD   = 5'd5,
    OP_SUB   = 5'd6,
    OP_MUL   = 5'd7,
    OP_DIV   = 5'd8,
    OP_REM   = 5'd9,
    OP_LT    = 5'd10,
    OP_LE    = 5'd11,
    OP_GT    = 5'd12,
    OP_GE    = 5'd13,
    OP_EQ    = 5'd14,
    OP_NE    = 5'd15,
    OP_LAND  = 5'd16,
    OP_LOR   = 5'd17,
    OP_NOT   = 5'd18,
    OP_NEG   = 5'd19,
    OP_JMP   = 5'd20,
    JZ       = 5'd21,
    RET      = 5'd22,
    HALT     = 5'd23,
    OP_LABEL = 5'd24
  } cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic signed [31:0] immediate;
    logic [SLOT_W-1:0]  var_slot;
    logic signed [31:0] read_value;
    logic [LABEL_W-1:0] label_id;
  } instr_t;

  typedef struct packed {
    logic               print_valid;
    logic signed [31:0] print_value;
    logic               jump_taken;
    logic [LABEL_W-1:0] jump_label;
    logic               finished;
    logic signed [31:0] exit_value;
    logic               stack_overflow;
  } result_t;
endpackage
`default_nettype wire

// File: rtl/core/svm_if.sv
// Valid/ready channel interfaces for instructions and results.
`timescale 1ns / 1ps
`default_nettype none
interface svm_in_if;
  logic valid;
  logic ready;
  svm_pkg::instr_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface svm_out_if;
  logic valid;
  logic ready;
  svm_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/svm_div.sv
// Radix-2 restoring signed divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module svm_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [31:0]      quot,
  output logic [31:0]      rem
);
  logic        busy_r;
  logic [5:0]  cnt_r;
  logic [31:0] q_r, r_r, d_r;
  logic        qneg_r, rneg_r, zero_r;
  logic [32:0] trial;
  logic [31:0] r_sh;

  assign r_sh  = {r_r[30:0], q_r[31]};
  assign trial = {1'b0, r_sh} - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd0;
        q_r    <= dividend[31] ? 32'd0 - dividend : dividend;
        d_r    <= divisor[31] ? 32'd0 - divisor : divisor;
        r_r    <= 32'd0;
        qneg_r <= dividend[31] ^ divisor[31];
        rneg_r <= dividend[31];
        zero_r <= (divisor == 32'd0);
      end else if (busy_r) begin
        if (!trial[32]) r_r <= trial[31:0];
        else r_r <= r_sh;
        q_r <= {q_r[30:0], ~trial[32]};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd31) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    quot = zero_r ? 32'd0 : (qneg_r ? 32'd0 - q_r : q_r);
    rem  = zero_r ? 32'd0 : (rneg_r ? 32'd0 - r_r : r_r);
  end
endmodule
`default_nettype wire

// File: rtl/core/stack_vm_execute_unit.sv
// Stack machine execute unit: operand stack and variable store in memories.
//
// Usage: one decoded instruction per transaction on in_ (valid/ready);
// one result transaction per instruction on out_. A result is held in an
// output register until taken; a new instruction is taken only once the
// previous result has left that register.
// Timing: the instruction passes through S_RD (memory read), then S_EX
// (execute and write back), and the result is registered; div and rem wait
// in S_DIV for the divider, which yields one quotient bit per cycle. A new
// instruction is accepted only after the previous one has left S_OUT, set by
// the stack memory read-modify-write and the single result register.
// Reset: stack count cleared; then the variable store is swept to zero,
// one slot a cycle, during which no instruction is accepted. The operand
// stack needs no clearing.
// Stall: while out_ready is low the result waits and in_ready stays low.
`timescale 1ns / 1ps
`default_nettype none
module stack_vm_execute_unit #(
  parameter int unsigned STACK_DEPTH = 64,
  parameter int unsigned VAR_SLOTS   = 256
) (
  input  wire logic clk,
  input  wire logic rst_n,
  svm_in_if.sink    in_ch,
  svm_out_if.source out_ch
);
  import svm_pkg::*;

  localparam int unsigned SA_W = $clog2(STACK_DEPTH);
  localparam int unsigned SC_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned VA_W = $clog2(VAR_SLOTS);
  localparam int unsigned VC_W = $clog2(VAR_SLOTS + 1);

  typedef enum logic [5:0] {
    S_CLR  = 6'b000001,
    S_IDLE = 6'b000010,
    S_RD   = 6'b000100,
    S_EX   = 6'b001000,
    S_DIV  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t            state_r;
  logic [SC_W-1:0]   cnt_r;
  logic [VC_W-1:0]   clr_r;
  instr_t            ins_r;
  logic [31:0]       stk_mem [STACK_DEPTH];
  logic [31:0]       var_mem [VAR_SLOTS];
  logic [31:0]       top_q, sec_q, var_q;
  logic [SA_W-1:0]   rd_a0, rd_a1;
  result_t           res_r;
  logic              out_v_r;
  logic              slot_ok;
  logic [VA_W-1:0]   slot_a;
  logic              div_start, div_done;
  logic [31:0]       div_q, div_r;
  logic [31:0]       a_v, b_v, alu;
  logic              n1, n2;
  logic signed [31:0] sa, sb;

  generate
    if (VA_W >= SLOT_W) begin : g_sw
      assign slot_a  = VA_W'(ins_r.var_slot);
      assign slot_ok = (VC_W'(ins_r.var_slot) < VC_W'(VAR_SLOTS)) || (VA_W > SLOT_W);
    end else begin : g_sn
      assign slot_a  = ins_r.var_slot[VA_W-1:0];
      assign slot_ok = ins_r.var_slot < SLOT_W'(VAR_SLOTS);
    end
  endgenerate

  assign rd_a0 = SA_W'(cnt_r - SC_W'(1));
  assign rd_a1 = SA_W'(cnt_r - SC_W'(2));
  assign n1 = cnt_r >= SC_W'(1);
  assign n2 = cnt_r >= SC_W'(2);

  always_ff @(posedge clk) begin
    top_q <= stk_mem[rd_a0];
    sec_q <= stk_mem[rd_a1];
    var_q <= var_mem[slot_a];
  end

  // operands: b is top, a is the one below
  assign b_v = n1 ? top_q : 32'd0;
  assign a_v = n2 ? sec_q : 32'd0;
  assign sa = a_v;
  assign sb = b_v;

  always_comb begin
    unique case (ins_r.cmd)
      OP_ADD:  alu = a_v + b_v;
      OP_SUB:  alu = a_v - b_v;
      OP_MUL:  alu = a_v * b_v;
      OP_LT:   alu = {31'd0, sa < sb};
      OP_LE:   alu = {31'd0, sa <= sb};
      OP_GT:   alu = {31'd0, sa > sb};
      OP_GE:   alu = {31'd0, sa >= sb};
      OP_EQ:   alu = {31'd0, a_v == b_v};
      OP_NE:   alu = {31'd0, a_v != b_v};
      OP_LAND: alu = {31'd0, (a_v != 0) && (b_v != 0)};
      default: alu = {31'd0, (a_v != 0) || (b_v != 0)};
    endcase
  end

  assign div_start = (state_r == S_EX) &&
                     (ins_r.cmd == OP_DIV || ins_r.cmd == OP_REM);

  svm_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .dividend(a_v), .divisor(b_v), .done(div_done),
    .quot(div_q), .rem(div_r)
  );

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_v_r;
  assign out_ch.data  = res_r;

  // stack write: pop count then push
  logic            pw_en;
  logic [31:0]     pw_d;
  logic [SC_W-1:0] base;
  logic            v_we;
  logic [31:0]     v_d;

  always_comb begin
    pw_en = 1'b0;
    pw_d  = alu;
    base  = cnt_r;
    v_we  = 1'b0;
    v_d   = b_v;
    unique case (ins_r.cmd) inside
      PUSH:     begin pw_en = 1'b1; pw_d = ins_r.immediate; end
      OP_LOAD:  begin pw_en = 1'b1; pw_d = slot_ok ? var_q : 32'd0; end
      OP_STORE: begin base = n1 ? cnt_r - SC_W'(1) : cnt_r; v_we = slot_ok; end
      OP_READ:  begin v_we = slot_ok; v_d = ins_r.read_value; end
      OP_PRINT, JZ, RET: base = n1 ? cnt_r - SC_W'(1) : cnt_r;
      OP_NOT:   begin
        base = n1 ? cnt_r - SC_W'(1) : cnt_r;
        pw_en = 1'b1; pw_d = {31'd0, b_v == 32'd0};
      end
      OP_NEG:   begin base = n1 ? cnt_r - SC_W'(1) : cnt_r; pw_en = 1'b1; pw_d = 32'd0 - b_v; end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_REM, OP_LT, OP_LE, OP_GT, OP_GE,
      OP_EQ, OP_NE, OP_LAND, OP_LOR: begin
        base = n2 ? cnt_r - SC_W'(2) : SC_W'(0);
        pw_en = 1'b1;
        if (ins_r.cmd == OP_DIV) pw_d = div_q;
        else if (ins_r.cmd == OP_REM) pw_d = div_r;
      end
      default: ;
    endcase
  end

  logic full;
  assign full = base >= SC_W'(STACK_DEPTH);

  always_ff @(posedge clk) begin
    if (state_r == S_CLR) var_mem[clr_r[VA_W-1:0]] <= 32'd0;
    else if (state_r == S_EX && v_we) var_mem[slot_a] <= v_d;
    if (((state_r == S_EX && !div_start) || (state_r == S_DIV && div_done))
        && pw_en && !full)
      stk_mem[base[SA_W-1:0]] <= pw_d;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      cnt_r   <= '0;
      clr_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) out_v_r <= 1'b0;
      unique case (state_r)
        S_CLR: begin
          clr_r <= clr_r + VC_W'(1);
          if (clr_r == VC_W'(VAR_SLOTS - 1)) state_r <= S_IDLE;
        end
        S_IDLE: if (in_ch.valid) begin
          ins_r   <= in_ch.data;
          state_r <= S_RD;
        end
        S_RD: state_r <= S_EX;
        S_EX, S_DIV: begin
          if (div_start) state_r <= S_DIV;
          else if (state_r == S_EX || div_done) begin
            cnt_r <= (pw_en && !full) ? base + SC_W'(1) : base;
            res_r.print_valid    <= ins_r.cmd == OP_PRINT;
            res_r.print_value    <= (ins_r.cmd == OP_PRINT) ? b_v : 32'd0;
            res_r.jump_taken     <= (ins_r.cmd == OP_JMP) ||
                                    (ins_r.cmd == JZ && b_v == 32'd0);
            res_r.jump_label     <= ((ins_r.cmd == OP_JMP) ||
                                    (ins_r.cmd == JZ && b_v == 32'd0)) ?
                                    ins_r.label_id : '0;
            res_r.finished       <= (ins_r.cmd == RET) || (ins_r.cmd == HALT);
            res_r.exit_value     <= (ins_r.cmd == RET) ? b_v : 32'd0;
            res_r.stack_overflow <= pw_en && full;
            out_v_r <= 1'b1;
            state_r <= S_OUT;
          end
        end
        S_OUT: if (!out_v_r || out_ch.ready) state_r <= S_IDLE;
        default: state_r <= S_CLR;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= SC_W'(STACK_DEPTH)) else $error("stack count overflow");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> !in_ch.ready) else $error("accept with result pending");
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV) else $error("stray divider done");
`endif
endmodule
`default_nettype wire
